>>> hw/rtl/bfmt_pkg.sv
// ----------------------------------------------------------------------------
// bfmt_pkg
// shared types and constants for the bloom filter membership test block
// ----------------------------------------------------------------------------
package bfmt_pkg;

   localparam int DIGEST_W     = 64;
   localparam int WORD_W       = 64;
   localparam int WORD_IDX_W   = 10;
   localparam int NUM_BITS_W   = 17;
   localparam int NUM_HASHES_W = 6;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 17;

   // filter bit position within one store word
   localparam int BIT_SEL_W = 6;

   // remainder unit: bits of the dividend consumed per cycle
   localparam int REM_DIGITS = 4;
   localparam int REM_STEPS  = DIGEST_W / REM_DIGITS;
   localparam int REM_CNT_W  = $clog2(REM_STEPS);

   localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RESET   = 17'd65536;
   localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RESET = 6'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BITS   = 1'b0,
      CSR_NUM_HASHES = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // status of the remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

>>> hw/rtl/bloom_filter_membership_test.sv
// ----------------------------------------------------------------------------
// bloom_filter_membership_test
// bloom filter bit store with double hashing membership queries
// ----------------------------------------------------------------------------
//
// channel   direction  handshake         payload
// req_*     in         req_valid/stall   cmd, word_index, word_value, digest_a..d
// rsp_*     out        rsp_valid/stall   present (one per query, none per load)
// csr_*     in         csr_wr_en         csr_index, csr_wdata
//
// a load writes the store word at its accept edge
// a query holds off the next request until its answer reaches the output
// register; each probe forms the probe location, runs the shared remainder
// unit (64 bits at 4 bits per cycle), hands the remainder over and starts
// the ram read, and tests the bit; a query ends at the first clear bit
// the block takes no request while a query runs; a finished answer waits in
// the output register so the next request is taken while rsp_stall is high
// reset sets control state and the configuration registers only; the store is undefined until loaded
//
module bloom_filter_membership_test
   import bfmt_pkg::*;
#(
   parameter int STORE_WORDS = 1024,
   parameter int MAX_PROBES  = 32
) (
   input  logic                    clock,
   input  logic                    reset,

   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic [WORD_IDX_W-1:0]   req_word_index,
   input  logic [WORD_W-1:0]       req_word_value,
   input  logic [DIGEST_W-1:0]     req_digest_a,
   input  logic [DIGEST_W-1:0]     req_digest_b,
   input  logic [DIGEST_W-1:0]     req_digest_c,
   input  logic [DIGEST_W-1:0]     req_digest_d,

   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_present,

   // configuration writes
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int PROBE_W = $clog2(MAX_PROBES + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOC  = 5'b00010,
      ST_WAIT = 5'b00100,
      ST_CHK  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   // configuration registers
   logic [NUM_BITS_W-1:0]   num_bits_ff, num_bits_in;
   logic [NUM_HASHES_W-1:0] num_hashes_ff, num_hashes_in;

   // sequencer and query context
   state_type               state_ff, state_in;
   logic [PROBE_W-1:0]      probe_ff, probe_in;
   logic [PROBE_W-1:0]      k_ff, k_in;
   logic [NUM_BITS_W-1:0]   m_ff, m_in;
   logic [DIGEST_W-1:0]     dig_a_ff, dig_a_in;
   logic [DIGEST_W-1:0]     dig_b_ff, dig_b_in;
   logic [DIGEST_W-1:0]     dig_c_ff, dig_c_in;
   logic [DIGEST_W-1:0]     dig_d_ff, dig_d_in;
   logic                    hit_ff, hit_in;
   logic [BIT_SEL_W-1:0]    bit_sel_ff, bit_sel_in;
   logic                    in_range_ff, in_range_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_present_ff, rsp_present_in;

   // datapath
   logic                    req_take;
   logic [1:0]              probe_lo;
   logic [DIGEST_W-1:0]     first_word;
   logic [DIGEST_W-1:0]     second_word;
   logic [DIGEST_W+PROBE_W-1:0] product;
   logic [DIGEST_W-1:0]     loc;
   logic                    rem_start;
   rem_stat_type            rem_stat;
   logic [NUM_BITS_W-1:0]   rem_value;
   logic [31:0]             probe_word;
   logic [31:0]             load_index;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]       ram_rd_data;
   logic                    probe_hit;
   logic                    out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // loads outside the store are dropped
   assign load_index = 32'(req_word_index);
   assign ram_wr_en  = req_take && (req_cmd == CMD_LOAD) &&
                       (load_index < 32'(STORE_WORDS));

   // probe i: first = w[i&1], second = w[2 + ((i>>1 ^ i)&1)]
   assign probe_lo    = 2'(probe_ff);
   assign first_word  = probe_lo[0] ? dig_b_ff : dig_a_ff;
   assign second_word = (probe_lo[1] ^ probe_lo[0]) ? dig_d_ff : dig_c_ff;
   assign product     = second_word * probe_ff;
   assign loc         = first_word + product[DIGEST_W-1:0];

   assign rem_start = (state_ff == ST_LOC);

   bfmt_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (loc),
      .divisor   (m_ff),
      .status    (rem_stat),
      .remainder (rem_value)
   );

   // store word holding the probed bit; beyond the store reads as clear
   assign probe_word  = 32'(rem_value >> BIT_SEL_W);
   assign ram_rd_en   = (state_ff == ST_WAIT) && rem_stat.done;
   assign ram_rd_addr = probe_word[ADDR_W-1:0];

   bfmt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_index[ADDR_W-1:0]),
      .wr_data (req_word_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign probe_hit = in_range_ff && ram_rd_data[bit_sel_ff];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      num_bits_in    = num_bits_ff;
      num_hashes_in  = num_hashes_ff;
      state_in       = state_ff;
      probe_in       = probe_ff;
      k_in           = k_ff;
      m_in           = m_ff;
      dig_a_in       = dig_a_ff;
      dig_b_in       = dig_b_ff;
      dig_c_in       = dig_c_ff;
      dig_d_in       = dig_d_ff;
      hit_in         = hit_ff;
      bit_sel_in     = bit_sel_ff;
      in_range_in    = in_range_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_BITS:   num_bits_in   = csr_wdata[NUM_BITS_W-1:0];
            CSR_NUM_HASHES: num_hashes_in = csr_wdata[NUM_HASHES_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_cmd == CMD_QUERY)) begin
               dig_a_in = req_digest_a;
               dig_b_in = req_digest_b;
               dig_c_in = req_digest_c;
               dig_d_in = req_digest_d;
               probe_in = '0;
               // zero filter size acts as one bit
               m_in = (num_bits_ff == '0) ? NUM_BITS_W'(1) : num_bits_ff;
               // probe count saturates at the build limit
               if (32'(num_hashes_ff) > 32'(MAX_PROBES)) begin
                  k_in = PROBE_W'(MAX_PROBES);
               end else begin
                  k_in = PROBE_W'(num_hashes_ff);
               end
               if (num_hashes_ff == '0) begin
                  hit_in   = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_LOC;
               end
            end
         end
         ST_LOC: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rem_stat.done) begin
               bit_sel_in  = rem_value[BIT_SEL_W-1:0];
               in_range_in = (probe_word < 32'(STORE_WORDS));
               state_in    = ST_CHK;
            end
         end
         ST_CHK: begin
            if (!probe_hit) begin
               hit_in   = 1'b0;
               state_in = ST_FIN;
            end else if ((probe_ff + 1'b1) == k_ff) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               probe_in = probe_ff + 1'b1;
               state_in = ST_LOC;
            end
         end
         ST_FIN: begin
            // answer waits here only while an older answer is still held
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = hit_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      probe_ff       <= probe_in;
      k_ff           <= k_in;
      m_ff           <= m_in;
      dig_a_ff       <= dig_a_in;
      dig_b_ff       <= dig_b_in;
      dig_c_ff       <= dig_c_in;
      dig_d_ff       <= dig_d_in;
      hit_ff         <= hit_in;
      bit_sel_ff     <= bit_sel_in;
      in_range_ff    <= in_range_in;
      rsp_present_ff <= rsp_present_in;
      if (reset) begin
         num_bits_ff   <= NUM_BITS_RESET;
         num_hashes_ff <= NUM_HASHES_RESET;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_bits_ff   <= num_bits_in;
         num_hashes_ff <= num_hashes_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

endmodule

>>> hw/rtl/bfmt_ram.sv
// ----------------------------------------------------------------------------
// bfmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bfmt_rem_unit.sv
// ----------------------------------------------------------------------------
// bfmt_rem_unit
// iterative 64-bit remainder by a 17-bit divisor, REM_DIGITS bits per cycle
// ----------------------------------------------------------------------------
module bfmt_rem_unit
   import bfmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIGEST_W-1:0]   dividend,
   input  logic [NUM_BITS_W-1:0] divisor,
   output rem_stat_type          status,
   output logic [NUM_BITS_W-1:0] remainder
);

   logic [DIGEST_W-1:0]   shift_ff, shift_in;
   logic [NUM_BITS_W-1:0] rem_ff, rem_in;
   logic [REM_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [NUM_BITS_W-1:0] step_rem;
   logic [NUM_BITS_W:0]   trial;

   // restoring remainder steps, msb first; divisor is at least 1
   always_comb begin
      step_rem = rem_ff;
      trial    = '0;
      for (int j = 0; j < REM_DIGITS; j++) begin
         trial = {step_rem, shift_ff[DIGEST_W-1-j]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         step_rem = trial[NUM_BITS_W-1:0];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << REM_DIGITS;
         rem_in   = step_rem;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == REM_CNT_W'(REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule
